>>> src/qsvr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package qsvr_pkg;

    localparam int NUM_KEYS   = 4;
    localparam int KEY_MAX    = 8;
    localparam int REDACT_LEN = 10;

    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3D;

    localparam logic [3:0] KEY_LEN_SAT = 4'd15;

    typedef enum logic [3:0] {
        PH_PATH = 4'b0001,
        PH_KEY  = 4'b0010,
        PH_VAL  = 4'b0100,
        PH_DROP = 4'b1000
    } phase_t;

    typedef struct packed {
        logic       present;
        logic [7:0] chr;
        logic       cvalid;
        logic       redact;
        logic       fin;
    } run_t;

    localparam logic [7:0] SECRET_TEXT [NUM_KEYS][KEY_MAX] = '{
        '{8'h70, 8'h77, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h70, 8'h61, 8'h73, 8'h73, 8'h77, 8'h6F, 8'h72, 8'h64},
        '{8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h6B, 8'h65, 8'h79, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [3:0] SECRET_LEN [NUM_KEYS] = '{4'd2, 4'd8, 4'd1, 4'd3};

    localparam logic [7:0] REDACT_TEXT [REDACT_LEN] = '{
        8'h3C, 8'h72, 8'h65, 8'h64, 8'h61, 8'h63, 8'h74, 8'h65, 8'h64, 8'h3E
    };

endpackage

`default_nettype wire

>>> src/qsvr_parse.sv
`timescale 1ns / 1ps
`default_nettype none

module qsvr_parse (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          take,
    input  wire logic [7:0]    char_in,
    input  wire logic          final_char,
    output qsvr_pkg::run_t     run
);
    import qsvr_pkg::*;

    phase_t                phase_reg, phase_next;
    logic [3:0]            key_len_reg, key_len_next;
    logic [NUM_KEYS-1:0]   match_reg, match_next;
    logic [NUM_KEYS-1:0]   match_upd;
    logic                  secret;
    logic                  emit;

    always_comb
    begin
        secret = 1'b0;
        for (int i = 0; i < NUM_KEYS; i++)
        begin
            if (match_reg[i] && key_len_reg == SECRET_LEN[i])
                secret = 1'b1;
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_KEYS; i++)
        begin
            match_upd[i] = match_reg[i];
            if (key_len_reg >= SECRET_LEN[i] ||
                SECRET_TEXT[i][key_len_reg[2:0]] != char_in)
                match_upd[i] = 1'b0;
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        key_len_next = key_len_reg;
        match_next   = match_reg;
        emit         = 1'b1;
        run.redact   = 1'b0;
        unique case (phase_reg)
            PH_PATH:
            begin
                if (char_in == CH_QUEST)
                begin
                    phase_next   = PH_KEY;
                    key_len_next = '0;
                    match_next   = '1;
                end
            end
            PH_KEY:
            begin
                if (char_in == CH_AMP)
                begin
                    key_len_next = '0;
                    match_next   = '1;
                end
                else if (char_in == CH_EQ)
                begin
                    run.redact = secret;
                    phase_next = secret ? PH_DROP : PH_VAL;
                end
                else
                begin
                    match_next = match_upd;
                    if (key_len_reg != KEY_LEN_SAT)
                        key_len_next = key_len_reg + 4'd1;
                end
            end
            PH_VAL:
            begin
                if (char_in == CH_AMP)
                begin
                    phase_next   = PH_KEY;
                    key_len_next = '0;
                    match_next   = '1;
                end
            end
            PH_DROP:
            begin
                emit = (char_in == CH_AMP);
                if (char_in == CH_AMP)
                begin
                    phase_next   = PH_KEY;
                    key_len_next = '0;
                    match_next   = '1;
                end
            end
            default:
            begin
                phase_next = PH_PATH;
            end
        endcase
        if (final_char)
        begin
            phase_next   = PH_PATH;
            key_len_next = '0;
            match_next   = '1;
        end
        run.present = emit || final_char;
        run.chr     = emit ? char_in : 8'h00;
        run.cvalid  = emit;
        run.fin     = final_char;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_PATH;
            key_len_reg <= '0;
            match_reg   <= '1;
        end
        else if (take)
        begin
            phase_reg   <= phase_next;
            key_len_reg <= key_len_next;
            match_reg   <= match_next;
        end
    end

endmodule

`default_nettype wire

>>> src/qsvr_emit.sv
`timescale 1ns / 1ps
`default_nettype none

module qsvr_emit (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          load,
    input  wire qsvr_pkg::run_t run,
    output logic               busy,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [7:0]         char_out,
    output logic               char_valid,
    output logic               run_end,
    output logic               target_end
);
    import qsvr_pkg::*;

    logic        valid_reg, valid_next;
    logic [7:0]  char_reg, char_next;
    logic        cvalid_reg, cvalid_next;
    logic        run_end_reg, run_end_next;
    logic        tend_reg, tend_next;
    logic        fin_reg, fin_next;
    logic [3:0]  rem_reg, rem_next;
    logic [3:0]  rix;
    logic        advance;

    assign advance = valid_reg && !out_stall;
    assign busy    = valid_reg && (out_stall || rem_reg != 4'd0);
    assign rix     = 4'(REDACT_LEN) - rem_reg;

    always_comb
    begin
        valid_next   = valid_reg;
        char_next    = char_reg;
        cvalid_next  = cvalid_reg;
        run_end_next = run_end_reg;
        tend_next    = tend_reg;
        fin_next     = fin_reg;
        rem_next     = rem_reg;
        if (advance && rem_reg != 4'd0)
        begin
            char_next    = REDACT_TEXT[rix];
            cvalid_next  = 1'b1;
            run_end_next = (rem_reg == 4'd1);
            tend_next    = (rem_reg == 4'd1) && fin_reg;
            rem_next     = rem_reg - 4'd1;
        end
        else if (load)
        begin
            valid_next   = run.present;
            char_next    = run.chr;
            cvalid_next  = run.cvalid;
            run_end_next = !run.redact;
            tend_next    = !run.redact && run.fin;
            fin_next     = run.fin;
            rem_next     = run.redact ? 4'(REDACT_LEN) : 4'd0;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rem_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            rem_reg   <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg    <= char_next;
        cvalid_reg  <= cvalid_next;
        run_end_reg <= run_end_next;
        tend_reg    <= tend_next;
        fin_reg     <= fin_next;
    end

    assign out_valid  = valid_reg;
    assign char_out   = char_reg;
    assign char_valid = cvalid_reg;
    assign run_end    = run_end_reg;
    assign target_end = tend_reg;

endmodule

`default_nettype wire

>>> src/query_secret_value_redactor.sv
// The first beat of an input byte's run is registered and appears in the cycle
// after acceptance. Throughput: one byte per cycle while out_stall is low; a
// secret-key '=' gives an 11-beat run, during which input stalls. Dropped value
// bytes give no beat, except a final one. Reset (rst_n low, async) returns the
// parser to the path phase and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module query_secret_value_redactor (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  char_in,
    input  wire logic        final_char,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       char_out,
    output logic             char_valid,
    output logic             run_end,
    output logic             target_end
);
    import qsvr_pkg::*;

    run_t run;
    logic busy;
    logic take;

    assign in_stall = busy;
    assign take     = in_valid && !busy;

    qsvr_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .char_in    (char_in),
        .final_char (final_char),
        .run        (run)
    );

    qsvr_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (take),
        .run        (run),
        .busy       (busy),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .char_out   (char_out),
        .char_valid (char_valid),
        .run_end    (run_end),
        .target_end (target_end)
    );

endmodule

`default_nettype wire
